>>> hw/rtl/gotp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gotp_pkg
// Shared constants, types and arithmetic helpers for the glyph outline decoder.
// ----------------------------------------------------------------------------
package gotp_pkg;

    // Largest polygon byte count accepted in a polygon header
    localparam int unsigned MAX_GLYPH_BYTES = 65536;
    localparam int unsigned MIN_POLY_BYTES  = 16;
    // Width of the remaining-byte counter of one polygon
    localparam int unsigned PBL_W = $clog2(MAX_GLYPH_BYTES + 1);

    localparam int unsigned COORD_W  = 32;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned NPOINT_W = 16;
    localparam int unsigned MAX_RES  = 3;
    localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);

    // Result payload: cmd, x, y, x2, y2 packed from bit 0, padded to bytes
    localparam int unsigned M_PAYLOAD_W = CMD_W + 4 * COORD_W;
    localparam int unsigned M_TDATA_W   = ((M_PAYLOAD_W + 7) / 8) * 8;
    localparam int unsigned S_TDATA_W   = WORD_W;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [COORD_W-1:0] coord_t;

    // Path command codes
    localparam cmd_t CMD_CLOSE = 3'd0;
    localparam cmd_t CMD_MOVE  = 3'd1;
    localparam cmd_t CMD_LINE  = 3'd2;
    localparam cmd_t CMD_CURVE = 3'd3;
    localparam cmd_t CMD_BAD   = 3'd4;

    // Curve record types
    localparam logic [15:0] CURVE_LINE = 16'd1;
    localparam logic [15:0] CURVE_QUAD = 16'd2;

    // Optional y negation, saturating the most negative value
    function automatic coord_t out_y(input coord_t v, input logic flip);
        coord_t r;
        r = v;
        if (flip) begin
            if (v == {1'b1, {(COORD_W-1){1'b0}}}) begin
                r = {1'b0, {(COORD_W-1){1'b1}}};
            end else begin
                r = ~v + coord_t'(1);
            end
        end
        return r;
    endfunction

    // Signed mean of two coordinates, truncated toward zero
    function automatic coord_t mid_point(input coord_t a, input coord_t b);
        logic signed [COORD_W:0] sum;
        logic signed [COORD_W:0] half;
        sum  = $signed({a[COORD_W-1], a}) + $signed({b[COORD_W-1], b});
        half = sum >>> 1;
        // Odd negative sum: step the floored half back up toward zero
        if (sum[COORD_W] && sum[0]) begin
            half = half + $signed({{COORD_W{1'b0}}, 1'b1});
        end
        return half[COORD_W-1:0];
    endfunction

endpackage

>>> hw/rtl/glyph_outline_to_path_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_outline_to_path_core
// Decodes a native glyph outline word stream into close, move, line, quadratic
// curve and malformed path commands, with optional saturating y negation.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                          tlast        tuser
//  s_        in   word[31:0]                     last_word    -
//  m_        out  cmd, x, y, x2, y2 (136 bits)   end_of_run   -
//  cfg_wr_   in   flip_y (1 bit), no handshake   -            -
//
// One word is taken per cycle while s_tready is high; it is decoded in the
// cycle it is accepted and its zero to three commands are held in a small
// result bank, shifted out one per cycle while m_tready is high. The next word
// enters as the last leaves: one word per cycle while each gives at most one.
// Reset is synchronous; it clears the parser and the bank and sets flip_y.
// The input is ready whenever the bank is empty or its last entry leaves now.
// ----------------------------------------------------------------------------
module glyph_outline_to_path_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration: flip_y
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    // Input stream, tdata: word[31:0]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gotp_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    // Result stream, tdata: cmd[2:0], x[34:3], y[66:35], x2[98:67], y2[130:99]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gotp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import gotp_pkg::*;

    // Parser phases
    localparam logic [2:0] PH_CB   = 3'd0;
    localparam logic [2:0] PH_TYPE = 3'd1;
    localparam logic [2:0] PH_SX   = 3'd2;
    localparam logic [2:0] PH_SY   = 3'd3;
    localparam logic [2:0] PH_CHDR = 3'd4;
    localparam logic [2:0] PH_PX   = 3'd5;
    localparam logic [2:0] PH_PY   = 3'd6;

    logic                 flip_y_reg;
    logic [2:0]           phase_reg, phase_next;
    logic [PBL_W-1:0]     pbl_reg, pbl_next;
    logic                 is_line_reg, is_line_next;
    logic                 is_quad_reg, is_quad_next;
    logic [NPOINT_W-1:0]  left_reg, left_next;
    logic                 first_reg, first_next;
    coord_t               prev_x_reg, prev_x_next;
    coord_t               prev_y_reg, prev_y_next;
    coord_t               held_x_reg, held_x_next;
    logic                 err_reg, err_next;

    // Result bank
    cmd_t                 slot_reg  [MAX_RES];
    cmd_t                 slot_next [MAX_RES];
    logic [RES_CNT_W-1:0] rem_reg, rem_next;
    coord_t               px_reg, py_reg, px2_reg, py2_reg;

    logic                 s_fire, m_fire;
    logic [WORD_W-1:0]    w;
    logic [PBL_W-1:0]     pbl_used;
    logic                 bytes_out;
    logic                 cb_bad;
    logic                 pre_close, main_v, post_close;
    cmd_t                 main_cmd;
    coord_t               ysrc, y2src, mid_x, mid_y;
    coord_t               res_x, res_y, res_x2, res_y2;
    logic [RES_CNT_W-1:0] cnt;
    logic                 pay_on;

    assign w        = s_tdata[WORD_W-1:0];
    assign s_tready = (rem_reg == '0) || ((rem_reg == RES_CNT_W'(1)) && m_tready);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_tvalid && m_tready;

    // Consume one word of the current polygon
    assign pbl_used  = (pbl_reg > PBL_W'(4)) ? pbl_reg - PBL_W'(4) : '0;
    assign bytes_out = (pbl_used == '0);
    assign cb_bad    = (w < WORD_W'(MIN_POLY_BYTES)) || (w > WORD_W'(MAX_GLYPH_BYTES));

    // Coordinates for the one payload-bearing command of a word
    assign mid_x = mid_point(prev_x_reg, held_x_reg);
    assign mid_y = mid_point(prev_y_reg, w);
    assign ysrc  = (phase_reg == PH_PY && is_quad_reg) ? prev_y_reg : w;
    assign y2src = (left_reg > NPOINT_W'(1)) ? mid_y : w;

    // Decode one word: parser update and command list
    always_comb begin
        phase_next   = phase_reg;
        pbl_next     = pbl_reg;
        is_line_next = is_line_reg;
        is_quad_next = is_quad_reg;
        left_next    = left_reg;
        first_next   = first_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        held_x_next  = held_x_reg;
        err_next     = err_reg;
        pre_close    = 1'b0;
        main_v       = 1'b0;
        main_cmd     = CMD_CLOSE;
        res_x        = held_x_reg;
        res_y        = out_y(ysrc, flip_y_reg);
        res_x2       = '0;
        res_y2       = '0;
        if (!err_reg) begin
            unique case (phase_reg)
                PH_CB: begin
                    if (cb_bad) begin
                        main_v   = 1'b1;
                        main_cmd = CMD_BAD;
                        err_next = 1'b1;
                    end else begin
                        pbl_next   = w[PBL_W-1:0] - PBL_W'(4);
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    pbl_next   = pbl_used;
                    phase_next = PH_SX;
                end
                PH_SX: begin
                    pbl_next    = pbl_used;
                    held_x_next = w;
                    phase_next  = PH_SY;
                end
                PH_SY: begin
                    pbl_next   = pbl_used;
                    pre_close  = 1'b1;
                    main_v     = 1'b1;
                    main_cmd   = CMD_MOVE;
                    phase_next = bytes_out ? PH_CB : PH_CHDR;
                end
                PH_CHDR: begin
                    pbl_next     = pbl_used;
                    is_line_next = (w[15:0] == CURVE_LINE);
                    is_quad_next = (w[15:0] == CURVE_QUAD);
                    left_next    = w[31:16];
                    first_next   = 1'b1;
                    if (bytes_out) begin
                        phase_next = PH_CB;
                    end else begin
                        phase_next = (w[31:16] != '0) ? PH_PX : PH_CHDR;
                    end
                end
                PH_PX: begin
                    pbl_next    = pbl_used;
                    held_x_next = w;
                    phase_next  = bytes_out ? PH_CB : PH_PY;
                end
                PH_PY: begin
                    pbl_next = pbl_used;
                    if (is_line_reg) begin
                        main_v   = 1'b1;
                        main_cmd = CMD_LINE;
                    end else if (is_quad_reg && !first_reg) begin
                        main_v   = 1'b1;
                        main_cmd = CMD_CURVE;
                        res_x    = prev_x_reg;
                        res_x2   = (left_reg > NPOINT_W'(1)) ? mid_x : held_x_reg;
                        res_y2   = out_y(y2src, flip_y_reg);
                    end
                    prev_x_next = held_x_reg;
                    prev_y_next = w;
                    first_next  = 1'b0;
                    left_next   = (left_reg != '0) ? left_reg - NPOINT_W'(1) : '0;
                    if (bytes_out) begin
                        phase_next = PH_CB;
                    end else begin
                        phase_next = (left_next != '0) ? PH_PX : PH_CHDR;
                    end
                end
                default: begin
                    phase_next = PH_CB;
                end
            endcase
        end
        // Final word: close and restart at a polygon header
        post_close = s_tlast;
        if (s_tlast) begin
            phase_next = PH_CB;
            pbl_next   = '0;
            left_next  = '0;
            err_next   = 1'b0;
        end
    end

    // Pack the command list of the word
    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            slot_next[i] = CMD_CLOSE;
        end
        cnt = '0;
        if (pre_close) begin
            slot_next[cnt[1:0]] = CMD_CLOSE;
            cnt = cnt + RES_CNT_W'(1);
        end
        if (main_v) begin
            slot_next[cnt[1:0]] = main_cmd;
            cnt = cnt + RES_CNT_W'(1);
        end
        if (post_close) begin
            slot_next[cnt[1:0]] = CMD_CLOSE;
            cnt = cnt + RES_CNT_W'(1);
        end
    end

    // Remaining-result count: load on a new transaction, drain on delivery
    always_comb begin
        rem_next = rem_reg;
        if (s_fire) begin
            rem_next = cnt;
        end else if (m_fire) begin
            rem_next = rem_reg - RES_CNT_W'(1);
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flip_y_reg  <= 1'b1;
            phase_reg   <= PH_CB;
            pbl_reg     <= '0;
            is_line_reg <= 1'b0;
            is_quad_reg <= 1'b0;
            left_reg    <= '0;
            first_reg   <= 1'b0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            held_x_reg  <= '0;
            err_reg     <= 1'b0;
            rem_reg     <= '0;
        end else begin
            if (cfg_wr_en) begin
                flip_y_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                phase_reg   <= phase_next;
                pbl_reg     <= pbl_next;
                is_line_reg <= is_line_next;
                is_quad_reg <= is_quad_next;
                left_reg    <= left_next;
                first_reg   <= first_next;
                prev_x_reg  <= prev_x_next;
                prev_y_reg  <= prev_y_next;
                held_x_reg  <= held_x_next;
                err_reg     <= err_next;
            end
            rem_reg <= rem_next;
        end
    end

    // Result bank payload: load on accept, shift commands on delivery
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            slot_reg <= slot_next;
            px_reg   <= res_x;
            py_reg   <= res_y;
            px2_reg  <= res_x2;
            py2_reg  <= res_y2;
        end else if (m_fire) begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    // Drive the result channel; close and malformed carry zero coordinates
    assign pay_on   = (slot_reg[0] == CMD_MOVE) || (slot_reg[0] == CMD_LINE)
                   || (slot_reg[0] == CMD_CURVE);
    assign m_tvalid = (rem_reg != '0);
    assign m_tlast  = (rem_reg == RES_CNT_W'(1));
    assign m_tdata  = {{(M_TDATA_W - M_PAYLOAD_W){1'b0}},
                       (slot_reg[0] == CMD_CURVE) ? py2_reg : coord_t'(0),
                       (slot_reg[0] == CMD_CURVE) ? px2_reg : coord_t'(0),
                       pay_on ? py_reg : coord_t'(0),
                       pay_on ? px_reg : coord_t'(0),
                       slot_reg[0]};

    // A malformed header parks the parser at the header phase
    a_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> phase_reg == PH_CB)
        else $error("error flag set outside header phase");

    // No bytes are outstanding while waiting for a polygon header
    a_cb_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_CB |-> pbl_reg == '0)
        else $error("byte count left over at polygon header");

    // Point phases are entered only with points still to read
    a_points: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PX || phase_reg == PH_PY) |-> left_reg != '0)
        else $error("point phase with no points left");

    // Commands of one word are delivered without a gap
    a_run_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("result run broken before its last command");

endmodule
